@@ rtl/spm_pkg.sv @@
// Shared types and constants for the sparse polynomial multiplier.
`default_nettype none
package spm_pkg;
  localparam int TermW = 16;
  localparam int CoefW = 40;
  localparam int ExpW  = 17;

  typedef enum logic [1:0] {
    OP_FIRST  = 2'd0,
    OP_SECOND = 2'd1,
    OP_END    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic signed [CoefW-1:0] CoefMax = {1'b0, {(CoefW-1){1'b1}}};
  localparam logic signed [CoefW-1:0] CoefMin = {1'b1, {(CoefW-1){1'b0}}};

  // Saturating 40-bit add.
  function automatic logic signed [CoefW-1:0] sat_add(
    input logic signed [CoefW-1:0] a,
    input logic signed [CoefW-1:0] b
  );
    logic signed [CoefW:0] s;
    s = {a[CoefW-1], a} + {b[CoefW-1], b};
    if (s[CoefW] != s[CoefW-1]) begin
      sat_add = s[CoefW] ? CoefMin : CoefMax;
    end else begin
      sat_add = s[CoefW-1:0];
    end
  endfunction
endpackage
`default_nettype wire

@@ rtl/sparse_polynomial_multiply.sv @@
// Sparse polynomial multiplier: term stores, product list and sequencer.
// Items with op 0 or 1 load a first or second term. An end item (op 2) runs the
// merge. For each product pair the sequencer steps through the pair, multiply,
// read and compare states. It then walks the product list from the cursor,
// reading and comparing each entry, and either adds in place or inserts; a
// zero product is skipped and one that finds the list full is dropped.
// An insert shifts the tail up one entry at a time, each a read then a write,
// and then writes the new entry. A scan pass then finds the last nonzero entry,
// and an emit pass sends each nonzero entry in turn, waiting on the output
// handshake, or a single zero result when no entry is nonzero. The stores
// clear by count reset, with no clearing pass.
`default_nettype none
module sparse_polynomial_multiply import spm_pkg::*; #(
  parameter int MAX_FIRST_TERMS   = 8,
  parameter int MAX_SECOND_TERMS  = 8,
  parameter int MAX_PRODUCT_TERMS = 64
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire  logic [1:0]           in_op,
  input  wire  logic signed [15:0]   in_term_coef,
  input  wire  logic signed [15:0]   in_term_exponent,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic signed [CoefW-1:0]    out_prod_coef,
  output logic signed [ExpW-1:0]     out_prod_exponent,
  output logic                       out_last,
  output logic                       out_dropped
);
  localparam int FW = $clog2(MAX_FIRST_TERMS + 1);
  localparam int SW = $clog2(MAX_SECOND_TERMS + 1);
  localparam int PW = $clog2(MAX_PRODUCT_TERMS + 1);
  localparam int FI = (MAX_FIRST_TERMS > 1) ? $clog2(MAX_FIRST_TERMS) : 1;
  localparam int SI = (MAX_SECOND_TERMS > 1) ? $clog2(MAX_SECOND_TERMS) : 1;
  localparam int PI = (MAX_PRODUCT_TERMS > 1) ? $clog2(MAX_PRODUCT_TERMS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_PAIR, S_MUL, S_RD, S_CMP, S_SHRD, S_SHWR, S_INS, S_SCANRD, S_SCAN,
    S_EMRD, S_EMIT, S_ZERO
  } state_t;

  state_t state_r;
  logic [FW-1:0] fcnt_r, i_r;
  logic [SW-1:0] scnt_r, j_r;
  logic [PW-1:0] pcnt_r, cur_r, m_r, last_r;
  logic          drop_r, found_r;

  logic signed [2*TermW-1:0] fmem [MAX_FIRST_TERMS];
  logic signed [2*TermW-1:0] smem [MAX_SECOND_TERMS];
  logic [CoefW+ExpW-1:0]     pmem [MAX_PRODUCT_TERMS];

  logic [2*TermW-1:0] fa_r, sb_r;
  logic [CoefW+ExpW-1:0] prd_r;
  logic [PI-1:0] raddr;
  logic signed [CoefW-1:0] p_coef;
  logic signed [ExpW-1:0]  p_exp;
  logic signed [CoefW-1:0] rd_c;
  logic signed [ExpW-1:0]  rd_e;

  spm_mult u_mult (
    .clk(clk), .a_coef(fa_r[31:16]), .a_exp(fa_r[15:0]),
    .b_coef(sb_r[31:16]), .b_exp(sb_r[15:0]), .p_coef(p_coef), .p_exp(p_exp)
  );

  assign rd_c = prd_r[CoefW+ExpW-1:ExpW];
  assign rd_e = prd_r[ExpW-1:0];
  assign in_ready = (state_r == S_IDLE) && !out_valid;

  // Product list read address by state
  always_comb begin
    unique case (state_r)
      S_SHRD:  raddr = PI'(m_r - 1'b1);
      S_SCANRD, S_EMRD, S_RD: raddr = PI'(cur_r);
      default: raddr = PI'(cur_r);
    endcase
  end

  // Term stores and reads
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_op == OP_FIRST && fcnt_r < FW'(MAX_FIRST_TERMS))
      fmem[FI'(fcnt_r)] <= {in_term_coef, in_term_exponent};
    if (in_valid && in_ready && in_op == OP_SECOND && scnt_r < SW'(MAX_SECOND_TERMS))
      smem[SI'(scnt_r)] <= {in_term_coef, in_term_exponent};
    fa_r  <= fmem[FI'(i_r)];
    sb_r  <= smem[SI'(j_r)];
    prd_r <= pmem[raddr];
  end

  // Product list writes
  always_ff @(posedge clk) begin
    if (state_r == S_CMP && cur_r < pcnt_r && rd_e == p_exp)
      pmem[PI'(cur_r)] <= {sat_add(rd_c, p_coef), rd_e};
    else if (state_r == S_CMP && !(cur_r < pcnt_r && rd_e < p_exp) &&
             pcnt_r < PW'(MAX_PRODUCT_TERMS) && m_r == cur_r)
      pmem[PI'(cur_r)] <= {p_coef, p_exp};
    else if (state_r == S_SHWR)
      pmem[PI'(m_r)] <= prd_r;
    else if (state_r == S_INS)
      pmem[PI'(cur_r)] <= {p_coef, p_exp};
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; fcnt_r <= '0; scnt_r <= '0; pcnt_r <= '0;
      drop_r <= 1'b0; out_valid <= 1'b0; i_r <= '0; j_r <= '0;
      cur_r <= '0; m_r <= '0; last_r <= '0; found_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              fcnt_r <= '0; scnt_r <= '0; pcnt_r <= '0; drop_r <= 1'b0;
            end else begin
              cur_r <= cur_r + 1'b1; state_r <= S_EMRD;
            end
          end else if (in_valid && in_ready) begin
            case (in_op)
              OP_FIRST:
                if (fcnt_r < FW'(MAX_FIRST_TERMS)) fcnt_r <= fcnt_r + 1'b1;
                else drop_r <= 1'b1;
              OP_SECOND:
                if (scnt_r < SW'(MAX_SECOND_TERMS)) scnt_r <= scnt_r + 1'b1;
                else drop_r <= 1'b1;
              OP_END: begin
                i_r <= '0; j_r <= '0; cur_r <= '0; state_r <= S_PAIR;
              end
              default: ;
            endcase
          end
        end
        S_PAIR: begin
          if (i_r >= FW'(fcnt_r) || scnt_r == '0) begin
            cur_r <= '0; found_r <= 1'b0; state_r <= S_SCANRD;
          end else if (j_r >= scnt_r) begin
            i_r <= i_r + 1'b1; j_r <= '0; cur_r <= '0;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_MUL: state_r <= S_RD;
        S_RD: begin
          m_r <= pcnt_r; state_r <= S_CMP;
        end
        S_CMP: begin
          if (p_coef == '0) begin
            j_r <= j_r + 1'b1; state_r <= S_PAIR;
          end else if (cur_r < pcnt_r && rd_e < p_exp) begin
            cur_r <= cur_r + 1'b1; state_r <= S_RD;
          end else if (cur_r < pcnt_r && rd_e == p_exp) begin
            j_r <= j_r + 1'b1; state_r <= S_PAIR;
          end else if (pcnt_r >= PW'(MAX_PRODUCT_TERMS)) begin
            drop_r <= 1'b1; j_r <= j_r + 1'b1; state_r <= S_PAIR;
          end else if (m_r == cur_r) begin
            pcnt_r <= pcnt_r + 1'b1; j_r <= j_r + 1'b1; state_r <= S_PAIR;
          end else begin
            state_r <= S_SHRD;
          end
        end
        S_SHRD: state_r <= S_SHWR;
        // Keep shifting until the slot at the cursor is free
        S_SHWR: begin
          m_r <= m_r - 1'b1;
          state_r <= (PW'(m_r - 1'b1) == cur_r) ? S_INS : S_SHRD;
        end
        S_INS: begin
          pcnt_r <= pcnt_r + 1'b1; j_r <= j_r + 1'b1; state_r <= S_PAIR;
        end
        S_SCANRD: begin
          if (cur_r >= pcnt_r) begin
            cur_r <= '0;
            state_r <= found_r ? S_EMRD : S_ZERO;
          end else state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (rd_c != '0) begin
            last_r <= cur_r; found_r <= 1'b1;
          end
          cur_r <= cur_r + 1'b1; state_r <= S_SCANRD;
        end
        S_EMRD: state_r <= S_EMIT;
        S_EMIT: begin
          if (rd_c == '0) begin
            cur_r <= cur_r + 1'b1; state_r <= S_EMRD;
          end else begin
            out_prod_coef <= rd_c; out_prod_exponent <= rd_e;
            out_last <= (cur_r == last_r); out_dropped <= drop_r;
            out_valid <= 1'b1; state_r <= S_IDLE;
          end
        end
        S_ZERO: begin
          out_prod_coef <= '0; out_prod_exponent <= '0; out_last <= 1'b1;
          out_dropped <= drop_r; out_valid <= 1'b1; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/spm_mult.sv @@
// Registered 16x16 signed multiplier and exponent adder shared by all products.
`default_nettype none
module spm_mult import spm_pkg::*; (
  input  wire                           clk,
  input  wire  logic signed [TermW-1:0] a_coef,
  input  wire  logic signed [TermW-1:0] a_exp,
  input  wire  logic signed [TermW-1:0] b_coef,
  input  wire  logic signed [TermW-1:0] b_exp,
  output logic signed [CoefW-1:0]       p_coef,
  output logic signed [ExpW-1:0]        p_exp
);
  logic signed [2*TermW-1:0] mul;
  assign mul = a_coef * b_coef;

  // One product per cycle, registered
  always_ff @(posedge clk) begin
    p_coef <= CoefW'(mul);
    p_exp  <= ExpW'(a_exp) + ExpW'(b_exp);
  end
endmodule
`default_nettype wire

@@ rtl/spm_checker.sv @@
// Port-level checker for the sparse polynomial multiplier, with its bind.
`default_nettype none
module spm_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [39:0] out_prod_coef,
  input wire        out_last
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_prod_coef))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_prod_coef != '0)
    else $error("zero coefficient emitted mid list");
endmodule
bind sparse_polynomial_multiply spm_checker u_spm_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_prod_coef(out_prod_coef), .out_last(out_last)
);
`default_nettype wire
